### src/zst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zst_pkg
// Shared defaults, direction codes and the control/status bundles of the
// zigzag swing tracker and its iterative divider.
// ---------------------------------------------------------------------------
package zst_pkg;

   localparam int PRICE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int AGE_WIDTH_DEF   = 16;

   // direction codes, two's complement
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_UP   = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### src/zst_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zst_divider
// Restoring divider, one quotient bit per cycle:
// quotient = floor(dividend * 2^FRAC_BITS / divisor), exact.
// ---------------------------------------------------------------------------
module zst_divider
   import zst_pkg::*;
#(
   parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  div_ctrl_type                       div_ctrl,
   input  logic [PRICE_WIDTH-1:0]             dividend,
   input  logic [PRICE_WIDTH-1:0]             divisor,
   output div_stat_type                       div_stat,
   output logic [PRICE_WIDTH+FRAC_BITS-1:0]   quotient
);

   localparam int QW    = PRICE_WIDTH + FRAC_BITS;
   localparam int CNT_W = $clog2(QW + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PRICE_WIDTH-1:0] rem_ff, rem_in;
   logic [PRICE_WIDTH-1:0] den_ff, den_in;
   logic [QW-1:0]     qd_ff, qd_in;
   logic [PRICE_WIDTH:0]   rem_sh;
   logic [PRICE_WIDTH:0]   rem_sub;
   logic              fits;

   assign rem_sh  = {rem_ff, qd_ff[QW-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      qd_in   = qd_ff;
      if (div_ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QW);
         rem_in  = '0;
         den_in  = divisor;
         qd_in   = {dividend, {FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? rem_sub[PRICE_WIDTH-1:0] : rem_sh[PRICE_WIDTH-1:0];
         qd_in  = {qd_ff[QW-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      qd_ff  <= qd_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = busy_ff && (cnt_ff == CNT_W'(1));
   assign quotient      = qd_ff;

endmodule

### src/zst_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zst_sequencer
// Per-sample sequencer: swing state, move measurement, reversal decision
// and the registered result.
// ---------------------------------------------------------------------------
module zst_sequencer
   import zst_pkg::*;
#(
   parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int AGE_WIDTH   = AGE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic                             csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [PRICE_WIDTH-1:0]           req_price,
   input  logic [PRICE_WIDTH-2:0]           req_threshold,
   input  logic                             req_threshold_valid,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [1:0]                       rsp_direction,
   output logic [PRICE_WIDTH-1:0]           rsp_inflection_price,
   output logic                             rsp_inflection_valid,
   output logic [PRICE_WIDTH-2:0]           rsp_target_level,
   output logic                             rsp_target_valid,
   output logic [PRICE_WIDTH-1:0]           rsp_correction,
   output logic [AGE_WIDTH-1:0]             rsp_swing_age,
   output div_ctrl_type                     div_ctrl,
   input  div_stat_type                     div_stat,
   output logic [PRICE_WIDTH-1:0]           div_dividend,
   output logic [PRICE_WIDTH-1:0]           div_divisor,
   input  logic [PRICE_WIDTH+FRAC_BITS-1:0] div_quotient
);

   localparam int PW = PRICE_WIDTH;
   localparam int QW = PRICE_WIDTH + FRAC_BITS;

   localparam logic [QW-1:0] ONE_X = {{(QW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [QW:0] SMAX_X = {{(QW-PW+2){1'b0}}, {(PW-1){1'b1}}};
   localparam logic signed [QW:0] SMIN_X = {{(QW-PW+2){1'b1}}, {(PW-1){1'b0}}};
   localparam logic [PW-1:0] SMAX_P = {1'b0, {(PW-1){1'b1}}};
   localparam logic [PW-1:0] SMIN_P = {1'b1, {(PW-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MEAS,
      ST_DEC
   } state_type;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_SEEK,
      PH_TREND
   } phase_type;

   function automatic logic [PW-1:0] clamp(input logic signed [QW:0] d);
      logic [PW-1:0] r;
      if (d > SMAX_X) begin
         r = SMAX_P;
      end else if (d < SMIN_X) begin
         r = SMIN_P;
      end else begin
         r = d[PW-1:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic                 percent_ff, percent_in;
   logic                 trend_up_ff, trend_up_in;
   logic [PW-1:0]        ext_ff, ext_in;
   logic [PW-2:0]        at_ff, at_in;
   logic                 atv_ff, atv_in;
   logic [PW-1:0]        ss_ff, ss_in;
   logic [AGE_WIDTH-1:0] age_ff, age_in;

   logic [PW-1:0]        p_ff, p_in;
   logic [PW-2:0]        thr_ff, thr_in;
   logic                 tv_ff, tv_in;
   logic                 newext_ff, newext_in;
   logic [PW-1:0]        rise_ff, rise_in;
   logic [PW-1:0]        fall_ff, fall_in;

   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]           dir_ff, dir_in;
   logic [PW-1:0]        infl_ff, infl_in;
   logic                 infl_v_ff, infl_v_in;
   logic [PW-2:0]        tgt_ff, tgt_in;
   logic                 tgt_v_ff, tgt_v_in;
   logic [PW-1:0]        corr_ff, corr_in;
   logic [AGE_WIDTH-1:0] oage_ff, oage_in;

   logic [QW-1:0]        meas_a, meas_b;
   logic signed [QW:0]   d_rise, d_fall;
   logic                 zero_ref;
   logic [PW-1:0]        ch_sel;
   logic [PW-1:0]        target_x;
   logic                 reverse, seek_up, seek_dn;
   logic [AGE_WIDTH-1:0] age_inc;
   logic                 show;
   logic [PW-1:0]        corr_val;
   logic                 commit;

   // percent mode compares the ratio with one, cash mode the prices;
   // a zero reference with a zero price measures no move
   assign meas_a   = percent_ff ? ((ext_ff == '0) ? ONE_X : div_quotient)
                                : {{FRAC_BITS{1'b0}}, p_ff};
   assign meas_b   = percent_ff ? ONE_X : {{FRAC_BITS{1'b0}}, ext_ff};
   assign d_rise   = $signed({1'b0, meas_a}) - $signed({1'b0, meas_b});
   assign d_fall   = $signed({1'b0, meas_b}) - $signed({1'b0, meas_a});
   assign zero_ref = percent_ff && (ext_ff == '0) && (p_ff != '0);

   assign target_x = {1'b0, at_ff};
   assign ch_sel   = trend_up_ff ? fall_ff : rise_ff;
   assign reverse  = atv_ff && ($signed(ch_sel) > $signed(target_x));
   assign seek_up  = atv_ff && ($signed(rise_ff) > $signed(target_x));
   assign seek_dn  = atv_ff && ($signed(fall_ff) > $signed(target_x));
   assign age_inc  = (age_ff == '1) ? age_ff : age_ff + AGE_WIDTH'(1);
   assign commit   = (state_ff == ST_DEC) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      percent_in    = csr_we ? csr_wdata : percent_ff;
      trend_up_in   = trend_up_ff;
      ext_in        = ext_ff;
      at_in         = at_ff;
      atv_in        = atv_ff;
      ss_in         = ss_ff;
      age_in        = age_ff;
      p_in          = p_ff;
      thr_in        = thr_ff;
      tv_in         = tv_ff;
      newext_in     = newext_ff;
      rise_in       = rise_ff;
      fall_in       = fall_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      dir_in        = dir_ff;
      infl_in       = infl_ff;
      infl_v_in     = infl_v_ff;
      tgt_in        = tgt_ff;
      tgt_v_in      = tgt_v_ff;
      corr_in       = corr_ff;
      oage_in       = oage_ff;
      div_ctrl.start = 1'b0;
      show          = 1'b0;
      corr_val      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               p_in     = req_price;
               thr_in   = req_threshold;
               tv_in    = req_threshold_valid;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            newext_in = trend_up_ff ? (p_ff >= ext_ff) : (p_ff <= ext_ff);
            if (percent_ff && (ext_ff != '0) &&
                ((phase_ff == PH_SEEK) || ((phase_ff == PH_TREND) && !newext_in))) begin
               div_ctrl.start = 1'b1;
               state_in       = ST_DIV;
            end else begin
               state_in = ST_MEAS;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_MEAS;
            end
         end
         ST_MEAS: begin
            rise_in  = zero_ref ? SMAX_P : clamp(d_rise);
            fall_in  = zero_ref ? SMIN_P : clamp(d_fall);
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (commit) begin
               case (phase_ff)
                  PH_TREND: begin
                     show = 1'b1;
                     if (newext_ff) begin
                        ext_in = p_ff;
                        at_in  = thr_ff;
                        atv_in = tv_ff;
                        age_in = age_inc;
                     end else if (reverse) begin
                        trend_up_in = !trend_up_ff;
                        ext_in      = p_ff;
                        ss_in       = p_ff;
                        at_in       = thr_ff;
                        atv_in      = tv_ff;
                        age_in      = '0;
                     end else begin
                        corr_val = ch_sel;
                        age_in   = age_inc;
                     end
                  end
                  PH_SEEK: begin
                     if (seek_up || seek_dn) begin
                        show        = 1'b1;
                        trend_up_in = seek_up;
                        phase_in    = PH_TREND;
                        ext_in      = p_ff;
                        ss_in       = p_ff;
                        at_in       = thr_ff;
                        atv_in      = tv_ff;
                        age_in      = '0;
                     end
                  end
                  default: begin
                     // anchor on the first sample with a usable threshold
                     if (tv_ff) begin
                        phase_in = PH_SEEK;
                        ext_in   = p_ff;
                        at_in    = thr_ff;
                        atv_in   = 1'b1;
                     end
                  end
               endcase

               rsp_tvalid_in = 1'b1;
               if (show) begin
                  dir_in    = trend_up_in ? DIR_UP : DIR_DOWN;
                  infl_in   = ss_in;
                  infl_v_in = 1'b1;
                  tgt_in    = atv_in ? at_in : '0;
                  tgt_v_in  = atv_in;
                  corr_in   = corr_val;
                  oage_in   = age_in;
               end else begin
                  dir_in    = DIR_NONE;
                  infl_in   = '0;
                  infl_v_in = 1'b0;
                  tgt_in    = '0;
                  tgt_v_in  = 1'b0;
                  corr_in   = '0;
                  oage_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_SKIP;
         percent_ff    <= 1'b0;
         trend_up_ff   <= 1'b0;
         ext_ff        <= '0;
         at_ff         <= '0;
         atv_ff        <= 1'b0;
         ss_ff         <= '0;
         age_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         percent_ff    <= percent_in;
         trend_up_ff   <= trend_up_in;
         ext_ff        <= ext_in;
         at_ff         <= at_in;
         atv_ff        <= atv_in;
         ss_ff         <= ss_in;
         age_ff        <= age_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      p_ff      <= p_in;
      thr_ff    <= thr_in;
      tv_ff     <= tv_in;
      newext_ff <= newext_in;
      rise_ff   <= rise_in;
      fall_ff   <= fall_in;
      dir_ff    <= dir_in;
      infl_ff   <= infl_in;
      infl_v_ff <= infl_v_in;
      tgt_ff    <= tgt_in;
      tgt_v_ff  <= tgt_v_in;
      corr_ff   <= corr_in;
      oage_ff   <= oage_in;
   end

   assign req_tready           = (state_ff == ST_IDLE);
   assign div_dividend         = p_ff;
   assign div_divisor          = ext_ff;
   assign rsp_tvalid           = rsp_tvalid_ff;
   assign rsp_direction        = dir_ff;
   assign rsp_inflection_price = infl_ff;
   assign rsp_inflection_valid = infl_v_ff;
   assign rsp_target_level     = tgt_ff;
   assign rsp_target_valid     = tgt_v_ff;
   assign rsp_correction       = corr_ff;
   assign rsp_swing_age        = oage_ff;

endmodule

### src/zigzag_swing_tracker_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zigzag_swing_tracker_unit
// Zigzag swing indicator: one result transaction for every price sample.
// ---------------------------------------------------------------------------
// Usage:
//   req channel carries one sample per transaction: price, reversal threshold
//   and (in req_tuser) the threshold-valid flag. rsp channel returns direction,
//   inflection price, target level, correction and swing age, with the
//   inflection and target valid flags in rsp_tuser.
//   csr_we/csr_wdata write percent_mode; write it only while no sample is open.
// Sequence:
//   An accepted sample passes through the states PREP, MEAS and DEC before
//   rsp_tvalid is raised, and a new sample is accepted only once the
//   sequencer is back in IDLE. In percent mode, when the move must be
//   measured against a nonzero extreme, the restoring divider adds the DIV
//   state between PREP and MEAS. req_tready is high only while the
//   sequencer is idle, so one sample is in work at a time.
// Reset and stall:
//   Reset clears the swing state, percent_mode and empties the output register.
//   A result waits in the output register while rsp_tready is low; the next
//   sample may be accepted meanwhile and completes once that register drains.
// ---------------------------------------------------------------------------
module zigzag_swing_tracker_unit
   import zst_pkg::*;
#(
   parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int AGE_WIDTH   = AGE_WIDTH_DEF,
   localparam int REQ_W = ((2 * PRICE_WIDTH - 1 + 7) / 8) * 8,
   localparam int RSP_W = ((3 * PRICE_WIDTH + 1 + AGE_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // price, reversal_threshold
   input  logic [REQ_W-1:0] req_tdata,
   // threshold_valid
   input  logic [0:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // direction, inflection_price, target_level, correction, swing_age
   output logic [RSP_W-1:0] rsp_tdata,
   // inflection_valid, target_valid
   output logic [1:0]       rsp_tuser
);

   localparam int PW    = PRICE_WIDTH;
   localparam int USED  = 3 * PW + 1 + AGE_WIDTH;

   div_ctrl_type                 div_ctrl;
   div_stat_type                 div_stat;
   logic [PW-1:0]                div_dividend;
   logic [PW-1:0]                div_divisor;
   logic [PW+FRAC_BITS-1:0]      div_quotient;

   logic [1:0]                   direction;
   logic [PW-1:0]                inflection_price;
   logic                         inflection_valid;
   logic [PW-2:0]                target_level;
   logic                         target_valid;
   logic [PW-1:0]                correction;
   logic [AGE_WIDTH-1:0]         swing_age;

   zst_divider #(
      .PRICE_WIDTH (PRICE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_stat (div_stat),
      .quotient (div_quotient)
   );

   zst_sequencer #(
      .PRICE_WIDTH (PRICE_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .AGE_WIDTH   (AGE_WIDTH)
   ) u_sequencer (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_price            (req_tdata[PW-1:0]),
      .req_threshold        (req_tdata[2*PW-2:PW]),
      .req_threshold_valid  (req_tuser[0]),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_direction        (direction),
      .rsp_inflection_price (inflection_price),
      .rsp_inflection_valid (inflection_valid),
      .rsp_target_level     (target_level),
      .rsp_target_valid     (target_valid),
      .rsp_correction       (correction),
      .rsp_swing_age        (swing_age),
      .div_ctrl             (div_ctrl),
      .div_stat             (div_stat),
      .div_dividend         (div_dividend),
      .div_divisor          (div_divisor),
      .div_quotient         (div_quotient)
   );

   assign rsp_tdata = {{(RSP_W-USED){1'b0}}, swing_age, correction, target_level,
                       inflection_price, direction};
   assign rsp_tuser = {target_valid, inflection_valid};

`ifndef SYNTHESIS
   // one sample in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while a sample is in work");

   // divider is never restarted mid-run and runs after a start
   assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy ##1 div_stat.busy)
      else $error("divider start overlaps a running division");

   // no swing yet: the whole result is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("nonzero result before a swing started");

   // a started swing always carries a direction
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[1:0] == DIR_UP) || (rsp_tdata[1:0] == DIR_DOWN))
      else $error("swing result without a direction");
`endif

endmodule
